[rtl/zero_nibble_rle_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the zero-nibble RLE decoder
// Concurrent checks clocked on clk; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ZERO_NIBBLE_RLE_DECODER_ASSERT_SVH
`define ZERO_NIBBLE_RLE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Check that is suspended while reset is asserted.
`define ZND_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds during reset.
`define ZND_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ZND_ASSERT(lbl, prop, msg)
`define ZND_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/zndec_pkg.sv]
// ----------------------------------------------------------------------------
// zndec_pkg
// Shared widths, result codes, command format and nibble decoding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package zndec_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned NIB_W       = 4;
    localparam int unsigned SIZE_W      = 17;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned TDATA_W     = 48;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Result kinds as seen on the output tuser.
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // Nibble decoding constants.
    localparam logic [NIB_W-1:0] LIT_BASE  = 4'd8;
    localparam logic [NIB_W-1:0] ZERO_BIAS = 4'd7;

    // One classified source byte: up to two runs, optional padding and status.
    typedef struct packed {
        logic              a_valid;
        logic [BYTE_W-1:0] a_value;
        logic [NIB_W-1:0]  a_count;
        logic              b_valid;
        logic [NIB_W-1:0]  b_count;
        logic              pad_req;
        logic              st_valid;
        logic [KIND_W-1:0] st_kind;
        logic [SIZE_W-1:0] written;
    } cmd_t;

    // Chunk length of a nibble: literals below 8, zero run from 8 up.
    function automatic logic [NIB_W-1:0] nib_count(input logic [NIB_W-1:0] nib);
        logic [NIB_W-1:0] cnt;
        if (nib[NIB_W-1])
        begin
            cnt = nib - ZERO_BIAS;
        end
        else
        begin
            cnt = LIT_BASE - nib;
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

[rtl/zero_nibble_rle_decoder.sv]
// ----------------------------------------------------------------------------
// zero_nibble_rle_decoder
// Zero-nibble run-length decoder: compressed bytes in, runs and status out.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Fields (low bit up)                        Beat
//   s_axis    in   tdata: in_byte[7:0]; tlast: in_last        one source byte
//   m_axis    out  tdata: out_value, out_count, out_written;  one result
//                  tuser: out_kind; tlast: out_last
//   cfg       in   cfg_data: dest_size[16:0]                  one register write
//
// The classifier takes a source byte every cycle while the four-entry command
// queue has room, and drops bytes at once after done or error.
// The sequencer sends one result beat per cycle while m_axis_tready allows; a byte
// gives zero to three beats through the single output port. A byte's first result
// passes through the command queue and then the output register.
// Reset is asynchronous and needs no clearing pass; dest_size returns to 65536
// (clipped to DEST_MAX). Either side may stall without blocking the other
// until the queue fills or drains.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_nibble_rle_decoder #(
    parameter int unsigned DEST_MAX = 65536
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [zndec_pkg::BYTE_W-1:0]    s_axis_tdata,   // in_byte[7:0]
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // out_value[7:0], out_count[24:8], out_written[41:25], zero fill
    output logic [zndec_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic [zndec_pkg::KIND_W-1:0]         m_axis_tuser,   // out_kind[1:0]
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [zndec_pkg::SIZE_W-1:0]    cfg_data
);

    logic                         q_full, q_empty, push, pop;
    zndec_pkg::cmd_t              push_cmd, head;
    logic [zndec_pkg::SIZE_W-1:0] lim;

    // Byte classifier and decoder state.
    zndec_front #(
        .DEST_MAX (DEST_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .push          (push),
        .push_cmd      (push_cmd),
        .lim           (lim)
    );

    // Command queue.
    zndec_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Result sequencer.
    zndec_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .lim           (lim),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[rtl/zndec_front.sv]
// ----------------------------------------------------------------------------
// zndec_front
// Accepts source bytes, tracks the decoder state and emits one command per
// byte that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zero_nibble_rle_decoder_assert.svh"

module zndec_front #(
    parameter int unsigned DEST_MAX = 65536
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [zndec_pkg::BYTE_W-1:0]   s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [zndec_pkg::SIZE_W-1:0]   cfg_data,
    input  wire logic                           q_full,
    output logic                                push,
    output zndec_pkg::cmd_t                     push_cmd,
    output logic [zndec_pkg::SIZE_W-1:0]        lim
);

    localparam int unsigned SW    = zndec_pkg::SIZE_W;
    localparam int unsigned NW    = zndec_pkg::NIB_W;
    localparam int unsigned MAX_W = $clog2(DEST_MAX + 1);
    localparam int unsigned CMP_W = (MAX_W > SW) ? MAX_W : SW;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(DEST_MAX);
    localparam int unsigned RST_SIZE = (DEST_MAX < 65536) ? DEST_MAX : 65536;

    localparam logic [1:0] MODE_RUN  = 2'd0;
    localparam logic [1:0] MODE_DONE = 2'd1;
    localparam logic [1:0] MODE_ERR  = 2'd2;

    logic [SW-1:0] lim_reg, lim_next;
    logic [SW-1:0] bw_reg, bw_next;
    logic [NW-1:0] ll_reg, ll_next;
    logic [NW-1:0] held_reg, held_next;
    logic          phase_reg, phase_next;
    logic [1:0]    mode_reg, mode_next;

    logic          accept;
    logic          is_lit;
    logic [NW-1:0] lo, hi, n2, k1, c2;
    logic [NW:0]   k2;
    logic [SW:0]   s1, s2, lim_ext;
    logic          s1_over, s1_full, s2_over, s2_full, bw_full;
    zndec_pkg::cmd_t cmd;

    // Configuration register, clipped to the buffer maximum on write.
    assign cfg_ready = 1'b1;
    assign lim       = lim_reg;
    always_comb
    begin
        lim_next = lim_reg;
        if (cfg_valid)
        begin
            lim_next = (CMP_W'(cfg_data) > MAX_C) ? SW'(MAX_C) : cfg_data;
        end
    end

    assign s_axis_tready = !q_full || (mode_reg != MODE_RUN);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Candidate byte counts for the first and second chunk, added in parallel.
    assign lo      = s_axis_tdata[NW-1:0];
    assign hi      = s_axis_tdata[2*NW-1:NW];
    assign is_lit  = (ll_reg != '0);
    assign k1      = is_lit ? NW'(1) : zndec_pkg::nib_count(lo);
    assign n2      = is_lit ? held_reg : hi;
    assign c2      = zndec_pkg::nib_count(n2);
    assign k2      = {1'b0, k1} + {1'b0, c2};
    assign s1      = {1'b0, bw_reg} + (SW + 1)'(k1);
    assign s2      = {1'b0, bw_reg} + (SW + 1)'(k2);
    assign lim_ext = {1'b0, lim_reg};
    assign s1_over = s1 > lim_ext;
    assign s1_full = s1 >= lim_ext;
    assign s2_over = s2 > lim_ext;
    assign s2_full = s2 >= lim_ext;
    assign bw_full = bw_reg >= lim_reg;

    // Classify the byte and build its command.
    always_comb
    begin
        cmd        = '0;
        push       = 1'b0;
        bw_next    = bw_reg;
        ll_next    = ll_reg;
        held_next  = held_reg;
        phase_next = phase_reg;
        mode_next  = mode_reg;
        if (accept && (mode_reg == MODE_RUN))
        begin
            push = 1'b1;
            if (is_lit)
            begin
                // Literal byte, possibly closing a chunk.
                cmd.a_valid = 1'b1;
                cmd.a_value = s_axis_tdata;
                cmd.a_count = NW'(1);
                bw_next     = s1[SW-1:0];
                ll_next     = ll_reg - NW'(1);
                if (s_axis_tlast)
                begin
                    cmd.pad_req  = 1'b1;
                    cmd.st_valid = 1'b1;
                    cmd.st_kind  = zndec_pkg::KIND_DONE;
                    cmd.written  = s1[SW-1:0];
                    mode_next    = MODE_DONE;
                end
                else if (ll_reg == NW'(1))
                begin
                    phase_next = !phase_reg;
                    if (s1_full)
                    begin
                        cmd.st_valid = 1'b1;
                        cmd.st_kind  = zndec_pkg::KIND_DONE;
                        cmd.written  = s1[SW-1:0];
                        mode_next    = MODE_DONE;
                    end
                    else if (!phase_reg)
                    begin
                        // Low nibble's literals are done: run the held high nibble.
                        if (s2_over)
                        begin
                            cmd.st_valid = 1'b1;
                            cmd.st_kind  = zndec_pkg::KIND_ERR;
                            cmd.written  = s1[SW-1:0];
                            mode_next    = MODE_ERR;
                        end
                        else if (!n2[NW-1])
                        begin
                            ll_next = c2;
                        end
                        else
                        begin
                            cmd.b_valid = 1'b1;
                            cmd.b_count = c2;
                            bw_next     = s2[SW-1:0];
                            phase_next  = 1'b0;
                            if (s2_full)
                            begin
                                cmd.st_valid = 1'b1;
                                cmd.st_kind  = zndec_pkg::KIND_DONE;
                                cmd.written  = s2[SW-1:0];
                                mode_next    = MODE_DONE;
                            end
                        end
                    end
                end
            end
            else if (bw_full)
            begin
                // Buffer already full when an opcode arrives.
                cmd.st_valid = 1'b1;
                cmd.st_kind  = zndec_pkg::KIND_DONE;
                cmd.written  = bw_reg;
                mode_next    = MODE_DONE;
            end
            else
            begin
                // Opcode byte.
                phase_next = 1'b0;
                held_next  = hi;
                if (s1_over)
                begin
                    cmd.st_valid = 1'b1;
                    cmd.st_kind  = zndec_pkg::KIND_ERR;
                    cmd.written  = bw_reg;
                    mode_next    = MODE_ERR;
                end
                else if (!lo[NW-1])
                begin
                    ll_next = k1;
                    if (s_axis_tlast)
                    begin
                        cmd.pad_req  = 1'b1;
                        cmd.st_valid = 1'b1;
                        cmd.st_kind  = zndec_pkg::KIND_DONE;
                        cmd.written  = bw_reg;
                        mode_next    = MODE_DONE;
                    end
                end
                else
                begin
                    cmd.a_valid = 1'b1;
                    cmd.a_count = k1;
                    bw_next     = s1[SW-1:0];
                    if (s_axis_tlast)
                    begin
                        cmd.pad_req  = 1'b1;
                        cmd.st_valid = 1'b1;
                        cmd.st_kind  = zndec_pkg::KIND_DONE;
                        cmd.written  = s1[SW-1:0];
                        mode_next    = MODE_DONE;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        if (s1_full)
                        begin
                            cmd.st_valid = 1'b1;
                            cmd.st_kind  = zndec_pkg::KIND_DONE;
                            cmd.written  = s1[SW-1:0];
                            mode_next    = MODE_DONE;
                        end
                        else if (s2_over)
                        begin
                            cmd.st_valid = 1'b1;
                            cmd.st_kind  = zndec_pkg::KIND_ERR;
                            cmd.written  = s1[SW-1:0];
                            mode_next    = MODE_ERR;
                        end
                        else if (!hi[NW-1])
                        begin
                            ll_next = c2;
                        end
                        else
                        begin
                            cmd.b_valid = 1'b1;
                            cmd.b_count = c2;
                            bw_next     = s2[SW-1:0];
                            phase_next  = 1'b0;
                            if (s2_full)
                            begin
                                cmd.st_valid = 1'b1;
                                cmd.st_kind  = zndec_pkg::KIND_DONE;
                                cmd.written  = s2[SW-1:0];
                                mode_next    = MODE_DONE;
                            end
                        end
                    end
                end
            end
            // Bytes that only start a literal chunk produce no result.
            push = cmd.a_valid || cmd.b_valid || cmd.st_valid;
        end
    end

    assign push_cmd = cmd;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg   <= SW'(RST_SIZE);
            bw_reg    <= '0;
            ll_reg    <= '0;
            held_reg  <= '0;
            phase_reg <= 1'b0;
            mode_reg  <= MODE_RUN;
        end
        else
        begin
            lim_reg   <= lim_next;
            bw_reg    <= bw_next;
            ll_reg    <= ll_next;
            held_reg  <= held_next;
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
        end
    end

    `ZND_ASSERT(a_halted_quiet, (mode_reg != MODE_RUN) |-> !push, "command issued after halt")
    `ZND_ASSERT(a_status_halts, (push && push_cmd.st_valid) |=> (mode_reg != MODE_RUN), "status without halt")

endmodule

`default_nettype wire

[rtl/zndec_fifo.sv]
// ----------------------------------------------------------------------------
// zndec_fifo
// Short command queue between the byte classifier and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zero_nibble_rle_decoder_assert.svh"

module zndec_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire zndec_pkg::cmd_t  push_cmd,
    input  wire logic             pop,
    output zndec_pkg::cmd_t       head,
    output logic                  empty,
    output logic                  full
);

    localparam int unsigned DEPTH = zndec_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    zndec_pkg::cmd_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `ZND_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
    `ZND_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty queue")

endmodule

`default_nettype wire

[rtl/zndec_back.sv]
// ----------------------------------------------------------------------------
// zndec_back
// Expands the command at the queue head into result beats, one per cycle unless
// stalled by m_axis_tready, through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zero_nibble_rle_decoder_assert.svh"

module zndec_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire zndec_pkg::cmd_t               head,
    input  wire logic                          q_empty,
    output logic                               pop,
    input  wire logic [zndec_pkg::SIZE_W-1:0]  lim,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [zndec_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic [zndec_pkg::KIND_W-1:0]       m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int unsigned SW = zndec_pkg::SIZE_W;
    localparam int unsigned BW = zndec_pkg::BYTE_W;

    // Piece order within one command.
    localparam int unsigned P_A   = 0;
    localparam int unsigned P_B   = 1;
    localparam int unsigned P_PAD = 2;
    localparam int unsigned P_ST  = 3;

    logic [3:0] served_reg, served_next;
    logic [3:0] mask, pending, pick;
    logic       pad_ok, is_last, load;
    logic [SW-1:0] pad_cnt;

    logic                          valid_reg, valid_next;
    logic [BW-1:0]                 value_reg, value_next;
    logic [SW-1:0]                 count_reg, count_next;
    logic [SW-1:0]                 written_reg, written_next;
    logic [zndec_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic                          last_reg, last_next;

    // Pieces of the head command still to be sent.
    assign pad_ok  = head.pad_req && (head.written < lim);
    assign pad_cnt = lim - head.written;
    assign mask    = {head.st_valid, pad_ok, head.b_valid, head.a_valid};
    assign pending = mask & ~served_reg;
    assign pick    = pending & ((~pending) + 4'd1);
    assign is_last = ((pending & ~pick) == 4'b0000);
    assign load    = !q_empty && (!valid_reg || m_axis_tready);
    assign pop     = load && is_last;

    // Build the next result beat.
    always_comb
    begin
        served_next  = served_reg;
        valid_next   = valid_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        written_next = written_reg;
        kind_next    = kind_reg;
        last_next    = last_reg;
        if (load)
        begin
            served_next  = is_last ? 4'b0000 : (served_reg | pick);
            valid_next   = 1'b1;
            value_next   = '0;
            count_next   = '0;
            written_next = '0;
            kind_next    = zndec_pkg::KIND_DATA;
            last_next    = is_last;
            if (pick[P_A])
            begin
                value_next = head.a_value;
                count_next = SW'(head.a_count);
            end
            else if (pick[P_B])
            begin
                count_next = SW'(head.b_count);
            end
            else if (pick[P_PAD])
            begin
                count_next = pad_cnt;
            end
            else if (pick[P_ST])
            begin
                kind_next    = head.st_kind;
                written_next = head.written;
            end
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg <= 4'b0000;
            valid_reg  <= 1'b0;
        end
        else
        begin
            served_reg <= served_next;
            valid_reg  <= valid_next;
        end
    end

    // Output payload holds while stalled.
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        count_reg   <= count_next;
        written_reg <= written_next;
        kind_reg    <= kind_next;
        last_reg    <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(zndec_pkg::TDATA_W - BW - 2 * SW)'(0), written_reg, count_reg,
                            value_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

    `ZND_ASSERT(a_head_pending, !q_empty |-> (pending != 4'b0000), "head command has nothing left")
    `ZND_ASSERT(a_served_idle, q_empty |-> (served_reg == 4'b0000), "stale served mask")

endmodule

`default_nettype wire

[dv/zero_nibble_rle_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-nibble RLE decoder testbench
// Feeds one compressed stream through the decoder with random idling and
// backpressure on both sides. An internal decoder predicts every result beat,
// and each beat leaving the block is checked field by field against the
// oldest prediction. The stream ends in one of four ways picked at random:
// the last source byte, a full buffer, an overflowing chunk, or a shrunk size.
// ----------------------------------------------------------------------------
module zero_nibble_rle_decoder_test;

    localparam int unsigned SIZE_CAP      = 65536;
    localparam int unsigned IDLE_PCT      = 7;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned HOLD_CYCLES   = 300;

    // Decoder state as the predictor tracks it.
    typedef enum logic [1:0] {DEC_RUNNING, DEC_DONE, DEC_ERROR} dec_mode_e;

    // Ways in which the stream is brought to its end.
    typedef enum logic [1:0] {END_BY_LAST, END_BY_FULL, END_BY_OVERFLOW, END_BY_SHRINK}
        stream_end_e;

    // One result beat: a run or a status report.
    typedef struct packed {
        logic [zndec_pkg::BYTE_W-1:0] value;
        logic [zndec_pkg::SIZE_W-1:0] count;
        logic [zndec_pkg::KIND_W-1:0] kind;
        logic [zndec_pkg::SIZE_W-1:0] written;
        logic                         last;
    } run_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [zndec_pkg::BYTE_W-1:0]  s_axis_tdata = '0;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [zndec_pkg::TDATA_W-1:0] m_axis_tdata;
    logic [zndec_pkg::KIND_W-1:0]  m_axis_tuser;
    logic                          m_axis_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [zndec_pkg::SIZE_W-1:0]  cfg_data = '0;

    // Predictor state and the queue of runs still to come out.
    logic [zndec_pkg::SIZE_W-1:0]  dest_size_shadow = 17'd65536;
    bit                            high_nibble_next = 1'b0;
    logic [zndec_pkg::NIB_W-1:0]   pending_high = '0;
    int unsigned                   literals_due = 0;
    int unsigned                   bytes_out = 0;
    dec_mode_e                     dec_mode = DEC_RUNNING;
    run_t                          step_runs[$];
    run_t                          expected_runs[$];

    // Run control shared by the stimulus and the response side.
    int unsigned         fail_count = 0;
    int unsigned         items_sent = 0;
    int unsigned         cycle_count = 0;
    int unsigned         sink_hold_left = 0;
    bit                  src_steady = 1'b0;
    bit                  sink_steady = 1'b0;

    zero_nibble_rle_decoder #(
        .DEST_MAX(SIZE_CAP)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // The size in use is the register clipped to the largest buffer.
    function automatic int unsigned buffer_limit();
        return (dest_size_shadow < SIZE_CAP) ? dest_size_shadow : SIZE_CAP;
    endfunction

    // Number of literals that a nibble asks for; zero for a zero run.
    function automatic int unsigned lit_count(input logic [zndec_pkg::NIB_W-1:0] nib);
        return nib[zndec_pkg::NIB_W-1] ? 0 : 8 - nib;
    endfunction

    // A byte never gives more than four result beats.
    function automatic void add_run(input logic [zndec_pkg::BYTE_W-1:0] value,
                                    input int unsigned count,
                                    input logic [zndec_pkg::KIND_W-1:0] kind,
                                    input int unsigned written);
        run_t r;
        if (step_runs.size() >= 4)
        begin
            return;
        end
        r.value   = value;
        r.count   = count[zndec_pkg::SIZE_W-1:0];
        r.kind    = kind;
        r.written = written[zndec_pkg::SIZE_W-1:0];
        r.last    = 1'b0;
        step_runs.insert(step_runs.size(), r);
    endfunction

    function automatic void report_done();
        add_run('0, 0, zndec_pkg::KIND_DONE, bytes_out);
        dec_mode = DEC_DONE;
    endfunction

    // Padding is only sent when some room is left.
    function automatic void pad_then_done();
        if (bytes_out < buffer_limit())
        begin
            add_run('0, buffer_limit() - bytes_out, zndec_pkg::KIND_DATA, 0);
        end
        report_done();
    endfunction

    // Starts the chunk of one nibble; returns 1 when it was a zero run that fit.
    function automatic bit start_nibble(input logic [zndec_pkg::NIB_W-1:0] nib, input bit last);
        int unsigned count;
        count = nib[zndec_pkg::NIB_W-1] ? nib - 7 : 8 - nib;
        if (bytes_out + count > buffer_limit())
        begin
            add_run('0, 0, zndec_pkg::KIND_ERR, bytes_out);
            dec_mode = DEC_ERROR;
            return 1'b0;
        end
        if (!nib[zndec_pkg::NIB_W-1])
        begin
            literals_due = count;
            if (last)
            begin
                pad_then_done();
            end
            return 1'b0;
        end
        add_run('0, count, zndec_pkg::KIND_DATA, 0);
        bytes_out = bytes_out + count;
        return 1'b1;
    endfunction

    // After a chunk: finish, stop on a full buffer, or move to the high nibble.
    function automatic void end_chunk(input bit last);
        if (last)
        begin
            pad_then_done();
            return;
        end
        high_nibble_next = !high_nibble_next;
        if (bytes_out >= buffer_limit())
        begin
            report_done();
            return;
        end
        if (high_nibble_next && start_nibble(pending_high, 1'b0))
        begin
            high_nibble_next = 1'b0;
            if (bytes_out >= buffer_limit())
            begin
                report_done();
            end
        end
    endfunction

    // Works out the result beats of one accepted source byte.
    function automatic void predict_byte(input logic [zndec_pkg::BYTE_W-1:0] data,
                                         input bit last);
        step_runs.delete();
        if (dec_mode != DEC_RUNNING)
        begin
            return;
        end
        if (literals_due > 0)
        begin
            add_run(data, 1, zndec_pkg::KIND_DATA, 0);
            bytes_out    = bytes_out + 1;
            literals_due = literals_due - 1;
            if (last)
            begin
                pad_then_done();
            end
            else if (literals_due == 0)
            begin
                end_chunk(1'b0);
            end
        end
        else if (bytes_out >= buffer_limit())
        begin
            report_done();
        end
        else
        begin
            high_nibble_next = 1'b0;
            pending_high     = data[7:4];
            if (start_nibble(data[3:0], last))
            begin
                end_chunk(last);
            end
        end
        // The final beat of the byte carries tlast.
        if (step_runs.size() > 0)
        begin
            step_runs[step_runs.size() - 1].last = 1'b1;
        end
        foreach (step_runs[i])
        begin
            expected_runs.insert(expected_runs.size(), step_runs[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------

    // Output ready: long holds on request, always ready when steady, otherwise random stalls.
    always @(posedge clk)
    begin
        if (sink_hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold_left = sink_hold_left - 1;
        end
        else if (sink_steady)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            fail_count = fail_count + 1;
            $display("%0t ns: %s expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    // Each result beat is checked against the oldest expected run.
    always @(posedge clk)
    begin : check_beat
        run_t got;
        run_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value   = m_axis_tdata[7:0];
            got.count   = m_axis_tdata[24:8];
            got.written = m_axis_tdata[41:25];
            got.kind    = m_axis_tuser;
            got.last    = m_axis_tlast;
            if (expected_runs.size() == 0)
            begin
                fail_count = fail_count + 1;
                $display("%0t ns: beat expected none, actual kind %0d count %0d",
                         $time, got.kind, got.count);
            end
            else
            begin
                want = expected_runs.pop_front();
                compare_field("out_value", want.value, got.value);
                compare_field("out_count", want.count, got.count);
                compare_field("out_kind", want.kind, got.kind);
                compare_field("out_written", want.written, got.written);
                compare_field("out_last", want.last, got.last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offers one source byte and predicts its results once it is taken.
    // Valid stays high after the beat so back-to-back bytes need no toggle.
    task automatic send_byte(input logic [zndec_pkg::BYTE_W-1:0] data, input bit last);
        if (!src_steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_byte(data, last);
        items_sent = items_sent + 1;
    endtask

    // Sends an opcode and the literals its nibbles call for. A cut index
    // marks that byte as the last one of the stream and stops there.
    task automatic send_group(input logic [zndec_pkg::BYTE_W-1:0] op, input int cut);
        int          total;
        int          idx;
        logic [7:0]  data;
        total = 1 + lit_count(op[3:0]) + lit_count(op[7:4]);
        for (idx = 0; idx < total; idx++)
        begin
            if (dec_mode != DEC_RUNNING)
            begin
                break;
            end
            if (idx == 0)
                data = op;
            else if ($urandom_range(3) == 0)
                data = {8{$urandom_range(1) == 1}};
            else
                data = 8'($urandom_range(255));
            send_byte(data, idx == cut);
            if (idx == cut)
            begin
                break;
            end
        end
    endtask

    // Stops the input and waits until every expected run has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_dest_size(input logic [zndec_pkg::SIZE_W-1:0] size);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dest_size_shadow = size;
    endtask

    // Zero runs and literal chunks in both nibble positions, extreme counts.
    task automatic test_directed_opcodes();
        send_group(8'hF8, -1);
        send_group(8'h8F, -1);
        send_group(8'h07, -1);
        send_group(8'h70, -1);
    endtask

    task automatic test_random_stream(input int unsigned n, input bit steady);
        int unsigned target;
        target      = items_sent + n;
        src_steady  = steady;
        sink_steady = steady;
        while (items_sent < target)
            send_group(8'($urandom_range(255)), -1);
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // The output is held off long enough that the block stalls its input.
    task automatic test_output_backpressure();
        sink_hold_left = HOLD_CYCLES;
        test_random_stream(30, 1'b0);
        drain_results();
    endtask

    // Ends the stream one of four ways, then checks that later bytes are dropped.
    task automatic test_stream_end();
        stream_end_e how;
        logic [7:0]  op;
        int unsigned margin;
        int          idx;
        how = stream_end_e'($urandom_range(3));
        op  = 8'($urandom_range(255));
        case (how)
            END_BY_LAST:
            begin
                send_group(op, $urandom_range(lit_count(op[3:0]) + lit_count(op[7:4])));
            end
            END_BY_FULL:
            begin
                write_dest_size(17'(bytes_out + $urandom_range(24, 1)));
                while (dec_mode == DEC_RUNNING)
                    send_group($urandom_range(1) ? 8'h88 : 8'($urandom_range(255)), -1);
            end
            END_BY_OVERFLOW:
            begin
                // The low nibble asks for more bytes than the room left.
                margin = $urandom_range(7);
                write_dest_size(17'(bytes_out + margin));
                if ($urandom_range(1))
                    op[3:0] = 4'($urandom_range(7 - margin));
                else
                    op[3:0] = 4'($urandom_range(15, 8 + margin));
                send_group(op, $urandom_range(1) ? 0 : -1);
            end
            default:
            begin
                write_dest_size($urandom_range(1) ? 17'd0 : 17'($urandom_range(bytes_out)));
                send_group(op, -1);
            end
        endcase
        for (idx = 0; idx < 8; idx++)
            send_byte(8'($urandom_range(255)), idx[0]);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_opcodes();
        write_dest_size(17'h1FFFF);
        test_random_stream(120, 1'b0);
        test_output_backpressure();
        write_dest_size(17'(bytes_out + 4096));
        test_random_stream(100, 1'b1);
        write_dest_size(17'd65536);
        test_random_stream(80, 1'b0);
        test_stream_end();
        drain_results();

        if (fail_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
